// ----- hdl/setq_pkg.sv -----
// ============================================================================
// setq_pkg
// shared widths, codes and structs of the sorted expiry timer queue
// ============================================================================
package setq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int MODE_W = 2;
    localparam int ID_W   = 16;
    localparam int MIN_W  = 16;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // slot read address select
    localparam logic [1:0] RD_HEAD = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_CUR  = 2'd2;
    localparam logic [1:0] RD_NEXT = 2'd3;

    // slot write data select
    localparam logic [1:0] WR_SHIFT = 2'd0;
    localparam logic [1:0] WR_NEW   = 2'd1;
    localparam logic [1:0] WR_DEC   = 2'd2;

    // scan index update
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_COUNT = 3'd2;
    localparam logic [2:0] IDX_INC   = 3'd3;
    localparam logic [2:0] IDX_DEC   = 3'd4;

    // entry count update
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   item_id;
        logic [MIN_W-1:0]  minutes;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              has_item;
        logic [ID_W-1:0]   out_id;
        logic [MIN_W-1:0]  out_minutes;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              load_in;
        logic [1:0]        rd_sel;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic [2:0]        idx_op;
        logic [1:0]        cnt_op;
        logic              cap;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              out_has;
        logic              out_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              full;
        logic              count_one;
        logic              idx_zero;
        logic              at_end;
        logic              rd_gt;
        logic              rd_match;
        logic              head_zero;
        logic              next_nonzero;
        logic              out_free;
    } dp_stat_t;

endpackage

// ----- hdl/setq_req_if.sv -----
// ============================================================================
// setq_req_if
// request channel: valid/ready with one queue command per beat
// ============================================================================
interface setq_req_if;
    import setq_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/setq_res_if.sv -----
// ============================================================================
// setq_res_if
// result channel: valid/ready with one queue result per beat
// ============================================================================
interface setq_res_if;
    import setq_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/setq_datapath.sv -----
// ============================================================================
// setq_datapath
// slot registers, scan index, entry count, capture and result registers
// ============================================================================
module setq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  setq_pkg::in_item_t  in_item,
    input  setq_pkg::ctl_cmd_t  cmd,
    input  logic                out_ready,
    output setq_pkg::dp_stat_t  stat,
    output logic                out_valid,
    output setq_pkg::out_item_t out_item
);
    import setq_pkg::*;

    logic [ID_W-1:0]  slot_ids_reg [DEPTH];
    logic [MIN_W-1:0] slot_min_reg [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    in_item_t         req_reg;
    logic [ID_W-1:0]  cap_id_reg;
    logic [MIN_W-1:0] cap_min_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [ID_W-1:0]  rd_id;
    logic [MIN_W-1:0] rd_min;
    logic [ID_W-1:0]  wr_id;
    logic [MIN_W-1:0] wr_min;
    logic [CNT_W-1:0] idx_ext;
    logic             out_free;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD: rd_addr = '0;
            RD_PREV: rd_addr = idx_reg - IDX_W'(1);
            RD_CUR:  rd_addr = idx_reg;
            RD_NEXT: rd_addr = idx_reg + IDX_W'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    assign rd_id  = slot_ids_reg[rd_addr];
    assign rd_min = slot_min_reg[rd_addr];

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_id  = rd_id;
                wr_min = rd_min;
            end
            WR_NEW:
            begin
                wr_id  = req_reg.item_id;
                wr_min = req_reg.minutes;
            end
            WR_DEC:
            begin
                wr_id  = rd_id;
                wr_min = (rd_min == '0) ? '0 : rd_min - MIN_W'(1);
            end
            default:
            begin
                wr_id  = rd_id;
                wr_min = rd_min;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:  idx_next = idx_reg;
            IDX_ZERO:  idx_next = '0;
            IDX_COUNT: idx_next = count_reg[IDX_W-1:0];
            IDX_INC:   idx_next = idx_reg + IDX_W'(1);
            IDX_DEC:   idx_next = idx_reg - IDX_W'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = count_reg - CNT_W'(1);
            default:  count_next = count_reg;
        endcase
    end

    assign idx_ext  = CNT_W'(idx_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.mode         = req_reg.mode;
        stat.empty        = (count_reg == '0);
        stat.full         = (count_reg == CNT_W'(DEPTH));
        stat.count_one    = (count_reg == CNT_W'(1));
        stat.idx_zero     = (idx_reg == '0);
        stat.at_end       = ((idx_ext + CNT_W'(1)) >= count_reg);
        stat.rd_gt        = (rd_min > req_reg.minutes);
        stat.rd_match     = (rd_id == req_reg.item_id);
        stat.head_zero    = (slot_min_reg[0] == '0);
        stat.next_nonzero = (slot_min_reg[1] != '0);
        stat.out_free     = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            slot_ids_reg[idx_reg] <= wr_id;
            slot_min_reg[idx_reg] <= wr_min;
        end
        if (cmd.load_in)
        begin
            req_reg <= in_item;
        end
        if (cmd.cap)
        begin
            cap_id_reg  <= rd_id;
            cap_min_reg <= rd_min;
        end
        if (cmd.out_load)
        begin
            out_item_reg.status      <= cmd.out_status;
            out_item_reg.has_item    <= cmd.out_has;
            out_item_reg.out_id      <= cmd.out_has ? cap_id_reg : '0;
            out_item_reg.out_minutes <= cmd.out_has ? cap_min_reg : '0;
            out_item_reg.occupancy   <= OCC_W'(count_reg - CNT_W'(cmd.out_has));
            out_item_reg.last        <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- hdl/setq_controller.sv -----
// ============================================================================
// setq_controller
// sequencer for insert, pop, remove and tick over the slot registers
// ============================================================================
module setq_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  setq_pkg::dp_stat_t stat,
    output logic               in_ready,
    output setq_pkg::ctl_cmd_t cmd
);
    import setq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;
    localparam logic [2:0] S_DROP = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STAT_W-1:0] resp_status_reg;
    logic [STAT_W-1:0] resp_status_next;
    logic              resp_has_reg;
    logic              resp_has_next;
    logic              resp_last_reg;
    logic              resp_last_next;
    logic              emitted_reg;
    logic              emitted_next;

    always_comb
    begin
        state_next       = state_reg;
        resp_status_next = resp_status_reg;
        resp_has_next    = resp_has_reg;
        resp_last_next   = resp_last_reg;
        emitted_next     = emitted_reg;
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.rd_sel       = RD_CUR;
        cmd.wr_sel       = WR_SHIFT;
        cmd.idx_op       = IDX_HOLD;
        cmd.cnt_op       = CNT_HOLD;
        cmd.out_status   = resp_status_reg;
        cmd.out_has      = resp_has_reg;
        cmd.out_last     = resp_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                resp_has_next  = 1'b0;
                resp_last_next = 1'b1;
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.full)
                        begin
                            resp_status_next = ST_FULL;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            state_next = S_INS;
                        end
                    end
                    MODE_POP:
                    begin
                        if (stat.empty)
                        begin
                            resp_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_sel       = RD_HEAD;
                            cmd.cap          = 1'b1;
                            cmd.idx_op       = IDX_ZERO;
                            resp_status_next = ST_OK;
                            resp_has_next    = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    MODE_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            resp_status_next = ST_EMPTY;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_SRCH;
                        end
                    end
                    default:
                    begin
                        if (stat.empty)
                        begin
                            resp_status_next = ST_OK;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            cmd.idx_op   = IDX_ZERO;
                            emitted_next = 1'b0;
                            state_next   = S_DEC;
                        end
                    end
                endcase
            end
            S_INS:
            begin
                cmd.rd_sel = RD_PREV;
                cmd.wr_en  = 1'b1;
                if (!stat.idx_zero && stat.rd_gt)
                begin
                    cmd.wr_sel = WR_SHIFT;
                    cmd.idx_op = IDX_DEC;
                end
                else
                begin
                    cmd.wr_sel       = WR_NEW;
                    cmd.cnt_op       = CNT_INC;
                    resp_status_next = ST_OK;
                    resp_has_next    = 1'b0;
                    resp_last_next   = 1'b1;
                    state_next       = S_RESP;
                end
            end
            S_SRCH:
            begin
                cmd.rd_sel = RD_CUR;
                if (stat.rd_match)
                begin
                    cmd.cap          = 1'b1;
                    resp_status_next = ST_OK;
                    resp_has_next    = 1'b1;
                    resp_last_next   = 1'b1;
                    state_next       = S_RESP;
                end
                else if (stat.at_end)
                begin
                    resp_status_next = ST_NOTFOUND;
                    resp_has_next    = 1'b0;
                    resp_last_next   = 1'b1;
                    state_next       = S_RESP;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DEC:
            begin
                cmd.rd_sel = RD_CUR;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DEC;
                if (stat.at_end)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_CHK:
            begin
                if (!stat.empty && stat.head_zero)
                begin
                    cmd.rd_sel       = RD_HEAD;
                    cmd.cap          = 1'b1;
                    cmd.idx_op       = IDX_ZERO;
                    emitted_next     = 1'b1;
                    resp_status_next = ST_EXPIRED;
                    resp_has_next    = 1'b1;
                    resp_last_next   = stat.count_one || stat.next_nonzero;
                    state_next       = S_RESP;
                end
                else if (!emitted_reg)
                begin
                    resp_status_next = ST_OK;
                    resp_has_next    = 1'b0;
                    resp_last_next   = 1'b1;
                    state_next       = S_RESP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = resp_has_reg ? S_DROP : S_IDLE;
                end
            end
            S_DROP:
            begin
                cmd.rd_sel = RD_NEXT;
                if (stat.at_end)
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = (stat.mode == MODE_TICK) ? S_CHK : S_IDLE;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SHIFT;
                    cmd.idx_op = IDX_INC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            resp_status_reg <= ST_OK;
            resp_has_reg    <= 1'b0;
            resp_last_reg   <= 1'b1;
            emitted_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
            resp_has_reg    <= resp_has_next;
            resp_last_reg   <= resp_last_next;
            emitted_reg     <= emitted_next;
        end
    end

endmodule

// ----- hdl/sorted_expiry_timer_queue.sv -----
// ============================================================================
// sorted_expiry_timer_queue
// timer queue of up to DEPTH id/minutes entries, sorted by minutes
// ============================================================================
// request carries mode, item_id and minutes; result carries status, has_item,
// out_id, out_minutes, occupancy and last. both are valid/ready channels.
// one request is taken at a time; it gives one result beat, except a tick
// that expires entries, which gives one beat per expired entry with last
// set on the final one.
// the sequencer walks the slots one entry per cycle through the slot
// read/write port: insert shifts entries with more minutes up a slot, then
// writes the new entry; pop takes the head and shifts the rest down; remove
// searches from the head and, if found, shifts the later entries down; tick
// lowers the minutes of every entry, not below zero, then pops entries with
// zero minutes from the head. errors and an empty tick skip the walk.
// the result register lets a new request be taken while the last beat of
// the previous one waits; a stalled result holds the sequencer at its next
// result beat. reset empties the queue at once; slots need no clearing.
// ============================================================================
module sorted_expiry_timer_queue (
    input logic        clk,
    input logic        rst_n,
    setq_req_if.sink   request,
    setq_res_if.source result
);
    import setq_pkg::*;

    ctl_cmd_t  cmd;
    dp_stat_t  stat;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_item;

    setq_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    setq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (request.data),
        .cmd       (cmd),
        .out_ready (result.ready),
        .stat      (stat),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign request.ready = in_ready;
    assign result.valid  = out_valid;
    assign result.data   = out_item;

endmodule

// ----- hdl/setq_checker.sv -----
// ============================================================================
// setq_checker
// port level checks of the timer queue, bound to the top level
// ============================================================================
module setq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                res_valid,
    input logic                res_ready,
    input setq_pkg::out_item_t res_data
);
    import setq_pkg::*;

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // no new request while more beats of a tick are due
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last |-> !req_ready)
        else $error("request taken in the middle of an expiry burst");

    // expiry beats carry an entry with zero minutes
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status == ST_EXPIRED)
        |-> res_data.has_item && (res_data.out_minutes == '0)
            && (res_data.occupancy < OCC_W'(DEPTH)))
        else $error("bad expiry beat");

    // error beats carry no entry and close the request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res_data.status == ST_FULL) || (res_data.status == ST_EMPTY)
            || (res_data.status == ST_NOTFOUND))
        |-> !res_data.has_item && res_data.last && (res_data.out_id == '0))
        else $error("bad error beat");

endmodule

bind sorted_expiry_timer_queue setq_checker u_setq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
